// ----- rtl/strd_pkg.sv -----
// ----------------------------------------------------------------------------
// strd_pkg
// Shared types and constants of the smoothed temperature readout unit:
// field widths, conversion constants, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package strd_pkg;

  // raw converter counts and smoothing
  localparam int COUNT_W   = 12;
  localparam int EMA_SHIFT = 5;
  localparam int AVG_W     = COUNT_W + EMA_SHIFT;

  // field and register widths
  localparam int TIME_W    = 32;
  localparam int CAL_W     = 12;
  localparam int IVL_W     = 16;
  localparam int DB_W      = 7;
  localparam int DEG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // register reset values
  localparam int VREF_CAL_RST = 1500;
  localparam int IVL_RST      = 50;
  localparam int DB_RST       = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VREF_CAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IVL      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd2;

  // conversion constants
  localparam int VDDA_CAL_MV    = 3300;
  localparam int V25_MV         = 760;
  localparam int ADC_FULL_SCALE = 4095;
  localparam int TENTHS_AT_25   = 250;
  localparam int TENTHS_PER_MV  = 4;
  localparam int TENTHS_PER_DEG = 10;
  localparam int TENTHS_LIMIT   = 9999;

  // divider sizing: supply division uses VDD_W bits, sensor division all
  localparam int VDD_W     = 24;
  localparam int DVD_W     = COUNT_W + VDD_W;
  localparam int DVS_W     = VDD_W;
  localparam int STEP_W    = 5;
  localparam int DIV1_STEPS = VDD_W / 2;
  localparam int DIV2_STEPS = DVD_W / 2;

  // tenths and rounding
  localparam int TEN_W     = 15;
  localparam int MAG_W     = 14;
  localparam int TMP_W     = VDD_W + 3;
  localparam int DIFF_W    = 16;
  localparam int RECIP_10  = 6554;
  localparam int RECIP_W   = 13;
  localparam int RECIP_SH  = 16;
  localparam int RPROD_W   = MAG_W + RECIP_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FOLD,
    S_DIV1_GO,
    S_DIV1_WAIT,
    S_MUL,
    S_DIV2_GO,
    S_DIV2_WAIT,
    S_ROUND,
    S_REPORT,
    S_FINISH
  } strd_state_t;

  typedef struct packed {
    logic load_in;
    logic fold;
    logic div1_go;
    logic vdda_load;
    logic mul;
    logic div2_go;
    logic tenths_load;
    logic round;
    logic report;
    logic out_load;
  } strd_cmd_t;

  typedef struct packed {
    logic primed;
    logic div_done;
    logic out_stall;
  } strd_stat_t;

endpackage

// ----- rtl/strd_div.sv -----
// ----------------------------------------------------------------------------
// strd_div
// Restoring unsigned divider, two quotient bits per cycle. The dividend is
// aligned to the top of its register and the step count sets how many bits
// are taken; the quotient sits in the low bits when done.
// ----------------------------------------------------------------------------
module strd_div
  import strd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  input  logic [STEP_W-1:0] steps,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  logic [DVD_W-1:0]  dq_r, dq_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DVS_W:0]    r1, r2;
  logic [DVS_W-1:0]  r1s, r2s;
  logic              q1, q2;

  // two dependent subtract steps
  always_comb begin
    r1  = {rem_r, dq_r[DVD_W-1]};
    q1  = (r1 >= {1'b0, dvs_r});
    r1s = q1 ? DVS_W'(r1 - {1'b0, dvs_r}) : r1[DVS_W-1:0];
    r2  = {r1s, dq_r[DVD_W-2]};
    q2  = (r2 >= {1'b0, dvs_r});
    r2s = q2 ? DVS_W'(r2 - {1'b0, dvs_r}) : r2[DVS_W-1:0];
  end

  // sequencing
  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DVD_W-3:0], q1, q2};
      rem_nxt = r2s;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = dq_r;
  assign done     = done_r;

endmodule

// ----- rtl/strd_ctrl.sv -----
// ----------------------------------------------------------------------------
// strd_ctrl
// Controller of the readout unit: walks a primed poll through fold, supply
// division, sensor scaling, rounding, deadband update and result hand-off.
// ----------------------------------------------------------------------------
module strd_ctrl
  import strd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  strd_stat_t stat,
  output strd_cmd_t  cmd
);

  strd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = S_DIV1_GO;
      end
      S_DIV1_GO: begin
        // no conversion until the averages are seeded
        if (stat.primed) begin
          cmd.div1_go = 1'b1;
          state_nxt   = S_DIV1_WAIT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_DIV1_WAIT: begin
        if (stat.div_done) begin
          cmd.vdda_load = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV2_GO;
      end
      S_DIV2_GO: begin
        cmd.div2_go = 1'b1;
        state_nxt   = S_DIV2_WAIT;
      end
      S_DIV2_WAIT: begin
        if (stat.div_done) begin
          cmd.tenths_load = 1'b1;
          state_nxt       = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!stat.out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/strd_dp.sv -----
// ----------------------------------------------------------------------------
// strd_dp
// Datapath of the readout unit: configuration registers, smoothing state,
// divider operands, sensor product, tenths clamp, rounding, deadband report
// and the output register.
// ----------------------------------------------------------------------------
module strd_dp
  import strd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic [COUNT_W-1:0]    in_sensor_count,
  input  logic [COUNT_W-1:0]    in_reference_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_available,
  output logic signed [DEG_W-1:0] out_degrees_c,
  input  strd_cmd_t             cmd,
  output strd_stat_t            stat,
  output logic                  div_start,
  output logic [DVD_W-1:0]      div_dividend,
  output logic [DVS_W-1:0]      div_divisor,
  output logic [STEP_W-1:0]     div_steps,
  input  logic [DVD_W-1:0]      div_quotient,
  input  logic                  div_done
);

  // configuration
  logic [CAL_W-1:0] vref_cal_r;
  logic [IVL_W-1:0] ivl_r;
  logic [DB_W-1:0]  db_r;

  // captured poll
  logic [TIME_W-1:0]  now_r;
  logic [COUNT_W-1:0] sen_in_r, ref_in_r;

  // smoothing state
  logic [AVG_W-1:0]  sen_avg_r, sen_avg_nxt;
  logic [AVG_W-1:0]  ref_avg_r, ref_avg_nxt;
  logic              primed_r, primed_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic signed [DEG_W-1:0] report_r;
  logic              rep_valid_r;

  // conversion pipeline
  logic [VDD_W-1:0]   vdda_r;
  logic [DVD_W-1:0]   prod_r;
  logic signed [TEN_W-1:0]  tenths_r;
  logic [RPROD_W-1:0] rprod_r;
  logic               neg_r;
  logic               upd_r;

  // output register
  logic                  out_valid_r;
  logic                  out_avail_r;
  logic signed [DEG_W-1:0] out_deg_r;

  logic [TIME_W-1:0]  elapsed;
  logic               do_fold;
  logic [COUNT_W-1:0] ref_avg_cnt, sen_avg_cnt;
  logic [VDD_W-1:0]   cal_mv;
  logic signed [TMP_W-1:0] t_raw;
  logic signed [TEN_W-1:0] t_sat;
  logic [MAG_W-1:0]   mag;
  logic signed [DIFF_W-1:0] rep_ext, rep_x10, diff, db_s;
  logic [DEG_W-1:0]   q_mag;
  logic signed [DEG_W-1:0] rounded;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_cal_r <= CAL_W'(VREF_CAL_RST);
      ivl_r      <= IVL_W'(IVL_RST);
      db_r       <= DB_W'(DB_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VREF_CAL: vref_cal_r <= cfg_data[CAL_W-1:0];
        CFG_IVL:      ivl_r      <= cfg_data[IVL_W-1:0];
        CFG_DEADBAND: db_r       <= cfg_data[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // poll capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r    <= in_now_ms;
      sen_in_r <= in_sensor_count;
      ref_in_r <= in_reference_count;
    end
  end

  // fold decision and moving average update
  assign elapsed = now_r - last_r;
  assign do_fold = !primed_r || (elapsed >= {{(TIME_W-IVL_W){1'b0}}, ivl_r});

  always_comb begin
    sen_avg_nxt = sen_avg_r;
    ref_avg_nxt = ref_avg_r;
    primed_nxt  = primed_r;
    last_nxt    = last_r;
    if (cmd.fold && do_fold) begin
      last_nxt = now_r;
      if (ref_in_r != '0) begin
        if (!primed_r) begin
          sen_avg_nxt = {sen_in_r, {EMA_SHIFT{1'b0}}};
          ref_avg_nxt = {ref_in_r, {EMA_SHIFT{1'b0}}};
          primed_nxt  = 1'b1;
        end else begin
          sen_avg_nxt = sen_avg_r - AVG_W'(sen_avg_r[AVG_W-1:EMA_SHIFT])
                        + AVG_W'(sen_in_r);
          ref_avg_nxt = ref_avg_r - AVG_W'(ref_avg_r[AVG_W-1:EMA_SHIFT])
                        + AVG_W'(ref_in_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sen_avg_r <= '0;
      ref_avg_r <= '0;
      primed_r  <= 1'b0;
      last_r    <= '0;
    end else begin
      sen_avg_r <= sen_avg_nxt;
      ref_avg_r <= ref_avg_nxt;
      primed_r  <= primed_nxt;
      last_r    <= last_nxt;
    end
  end

  // divider operands: supply first, then sensor voltage over full scale
  assign sen_avg_cnt = sen_avg_r[AVG_W-1:EMA_SHIFT];
  assign ref_avg_cnt = (ref_avg_r[AVG_W-1:EMA_SHIFT] == '0) ? COUNT_W'(1)
                       : ref_avg_r[AVG_W-1:EMA_SHIFT];
  assign cal_mv      = VDD_W'(VDDA_CAL_MV) * {{(VDD_W-CAL_W){1'b0}}, vref_cal_r};

  assign div_start = cmd.div1_go || cmd.div2_go;
  always_comb begin
    if (cmd.div1_go) begin
      div_dividend = {cal_mv, {COUNT_W{1'b0}}};
      div_divisor  = {{(DVS_W-COUNT_W){1'b0}}, ref_avg_cnt};
      div_steps    = STEP_W'(DIV1_STEPS);
    end else begin
      div_dividend = prod_r;
      div_divisor  = DVS_W'(ADC_FULL_SCALE);
      div_steps    = STEP_W'(DIV2_STEPS);
    end
  end

  // tenths from sensor millivolts, clamped
  assign t_raw = $signed({1'b0, div_quotient[VDD_W-1:0], 2'b00})
                 - TMP_W'(V25_MV * TENTHS_PER_MV - TENTHS_AT_25);
  always_comb begin
    if (t_raw > TMP_W'(TENTHS_LIMIT)) begin
      t_sat = TEN_W'(TENTHS_LIMIT);
    end else if (t_raw < -TMP_W'(TENTHS_LIMIT)) begin
      t_sat = -TEN_W'(TENTHS_LIMIT);
    end else begin
      t_sat = t_raw[TEN_W-1:0];
    end
  end

  // magnitude and deadband difference
  assign mag     = tenths_r[TEN_W-1] ? MAG_W'(-tenths_r) : tenths_r[MAG_W-1:0];
  assign rep_ext = DIFF_W'(report_r);
  assign rep_x10 = (rep_ext <<< 3) + (rep_ext <<< 1);
  assign diff    = DIFF_W'(tenths_r) - rep_x10;
  assign db_s    = $signed({{(DIFF_W-DB_W){1'b0}}, db_r});

  // round half away from zero via reciprocal of ten
  assign q_mag   = rprod_r[RECIP_SH +: DEG_W];
  assign rounded = neg_r ? -$signed(q_mag) : $signed(q_mag);

  always_ff @(posedge clk) begin
    if (cmd.vdda_load) begin
      vdda_r <= div_quotient[VDD_W-1:0];
    end
    if (cmd.mul) begin
      prod_r <= {{VDD_W{1'b0}}, sen_avg_cnt} * {{COUNT_W{1'b0}}, vdda_r};
    end
    if (cmd.tenths_load) begin
      tenths_r <= t_sat;
    end
    if (cmd.round) begin
      rprod_r <= RPROD_W'(mag + MAG_W'(5)) * RPROD_W'(RECIP_10);
      neg_r   <= tenths_r[TEN_W-1];
      upd_r   <= !rep_valid_r || (diff > db_s) || (diff < -db_s);
    end
  end

  // reported degree
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_r    <= '0;
      rep_valid_r <= 1'b0;
    end else if (cmd.report && upd_r) begin
      report_r    <= rounded;
      rep_valid_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_avail_r <= primed_r;
      out_deg_r   <= primed_r ? report_r : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_available = out_avail_r;
  assign out_degrees_c = out_deg_r;

  assign stat.primed    = primed_r;
  assign stat.div_done  = div_done;
  assign stat.out_stall = out_valid_r && !out_ready;

endmodule

// ----- rtl/smoothed_temp_sensor_readout_unit.sv -----
// ----------------------------------------------------------------------------
// smoothed_temp_sensor_readout_unit
// Smoothed temperature readout with deadband: each poll may fold a sample
// into two moving averages and yields one result with the reported degree.
// ----------------------------------------------------------------------------
// flow: a poll whose fold leaves the averages unseeded goes straight to the
//   result hand-off; once primed, the shared two-bits-per-cycle divider runs
//   for the supply and then the sensor voltage; a new poll is taken once the
//   output register loads, which lets the next poll start while a result waits
// reset: synchronous active-low; averages, report and timing clear,
//   registers return to 1500, 50 and 7
module smoothed_temp_sensor_readout_unit
  import strd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TIME_W-1:0]       in_now_ms,
  input  logic [COUNT_W-1:0]      in_sensor_count,
  input  logic [COUNT_W-1:0]      in_reference_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_available,
  output logic signed [DEG_W-1:0] out_degrees_c
);

  strd_cmd_t         cmd;
  strd_stat_t        stat;
  logic              div_start;
  logic [DVD_W-1:0]  div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic [STEP_W-1:0] div_steps;
  logic [DVD_W-1:0]  div_quotient;
  logic              div_done;

  // controller
  strd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  strd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_now_ms          (in_now_ms),
    .in_sensor_count    (in_sensor_count),
    .in_reference_count (in_reference_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_available      (out_available),
    .out_degrees_c      (out_degrees_c),
    .cmd                (cmd),
    .stat               (stat),
    .div_start          (div_start),
    .div_dividend       (div_dividend),
    .div_divisor        (div_divisor),
    .div_steps          (div_steps),
    .div_quotient       (div_quotient),
    .div_done           (div_done)
  );

  // shared divider
  strd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .quotient (div_quotient),
    .done     (div_done)
  );

endmodule
